>>> design/vbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbf_pkg: shared types and constants of the voice band-pass FIR
// Coefficient table, controller state type and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package vbf_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 16;
  localparam int AccW    = 32;
  localparam int TapIdxW = 7;
  localparam int CoefNum = 64;

  localparam logic signed [CoefW-1:0] COEF_TABLE [CoefNum] = '{
    16'sd1237,   16'sd507,    -16'sd869,   -16'sd1251,  -16'sd343,
    -16'sd105,   -16'sd614,   -16'sd236,   16'sd316,    -16'sd110,
    -16'sd67,    16'sd683,    16'sd407,    16'sd57,     16'sd866,
    16'sd823,    -16'sd13,    16'sd629,    16'sd945,    -16'sd391,
    -16'sd211,   16'sd656,    -16'sd1010,  -16'sd1656,  16'sd31,
    -16'sd1524,  -16'sd3612,  -16'sd674,   -16'sd1033,  -16'sd6749,
    -16'sd1137,  16'sd14332,  16'sd14332,  -16'sd1137,  -16'sd6749,
    -16'sd1033,  -16'sd674,   -16'sd3612,  -16'sd1524,  16'sd31,
    -16'sd1656,  -16'sd1010,  16'sd656,    -16'sd211,   -16'sd391,
    16'sd945,    16'sd629,    -16'sd13,    16'sd823,    16'sd866,
    16'sd57,     16'sd407,    16'sd683,    -16'sd67,    -16'sd110,
    16'sd316,    -16'sd236,   -16'sd614,   -16'sd105,   -16'sd343,
    -16'sd1251,  -16'sd869,   16'sd507,    16'sd1237
  };

  // Taps past the end of the table have a zero coefficient.
  function automatic logic signed [CoefW-1:0] coef_at(input logic [TapIdxW-1:0] idx);
    logic signed [CoefW-1:0] c;
    c = '0;
    if (idx < TapIdxW'(CoefNum)) begin
      c = COEF_TABLE[idx[5:0]];
    end
    return c;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_LOAD
  } vbf_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load;
  } vbf_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic busy;
    logic out_free;
  } vbf_stat_t;

endpackage
`default_nettype wire

>>> design/vbf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbf_ctrl: sequencer of the voice band-pass FIR
// Takes a sample, steps the datapath through one multiply-accumulate per
// tap, waits for the pipeline to empty and loads the output register.
// ----------------------------------------------------------------------------
module vbf_ctrl
  import vbf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire vbf_stat_t stat,
  output vbf_cmd_t       cmd
);

  vbf_state_t state_r;
  vbf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/vbf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbf_datapath: history memory and multiply-accumulate of the voice FIR
// Ring of past samples with a fill count for reset-zero reads, a registered
// multiplier, a 32-bit accumulator and the output register.
// ----------------------------------------------------------------------------
module vbf_datapath
  import vbf_pkg::*;
#(
  parameter int TAP_COUNT     = 64,
  parameter int HISTORY_DEPTH = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire vbf_cmd_t                  cmd,
  output vbf_stat_t                      stat,
  input  wire logic signed [SampleW-1:0] in_sample,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [SampleW-1:0]      out_sample
);

  localparam int PtrW = $clog2(HISTORY_DEPTH);
  localparam int FillW = $clog2(HISTORY_DEPTH + 1);
  localparam int TapW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  logic signed [SampleW-1:0] hist_mem [HISTORY_DEPTH];

  logic [PtrW-1:0]           wr_ptr_r;
  logic [FillW-1:0]          fill_r;
  logic [PtrW-1:0]           rd_ptr_r;
  logic [TapW-1:0]           tap_r;
  logic signed [SampleW-1:0] rd_data_r;
  logic                      rd_ok_r;
  logic                      rd_vld_r;
  logic signed [CoefW-1:0]   coef_r;
  logic signed [AccW-1:0]    prod_r;
  logic                      prod_vld_r;
  logic signed [AccW-1:0]    acc_r;
  logic                      out_valid_r;
  logic signed [SampleW-1:0] out_data_r;
  logic signed [SampleW-1:0] samp_m;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hist_mem[wr_ptr_r] <= in_sample;
    end
    if (cmd.issue) begin
      rd_data_r <= hist_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (cmd.accept) begin
      wr_ptr_r <= (wr_ptr_r == PtrW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      if (fill_r != FillW'(HISTORY_DEPTH)) begin
        fill_r <= fill_r + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ptr_r <= wr_ptr_r;
      tap_r    <= '0;
    end else if (cmd.issue) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? PtrW'(HISTORY_DEPTH - 1) : rd_ptr_r - PtrW'(1);
      tap_r    <= tap_r + TapW'(1);
    end
    if (cmd.issue) begin
      rd_ok_r <= FillW'(rd_ptr_r) < fill_r;
      coef_r  <= coef_at(TapIdxW'(tap_r));
    end
  end

  assign samp_m = rd_ok_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    prod_r <= samp_m * coef_r;
    if (cmd.accept) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.load) begin
      out_data_r <= acc_r[AccW-1:AccW-SampleW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.last_tap = (tap_r == TapW'(TAP_COUNT - 1));
  assign stat.busy     = rd_vld_r | prod_vld_r;
  assign stat.out_free = !out_valid_r | out_ready;

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;

endmodule
`default_nettype wire

>>> design/voice_bandpass_fir_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voice_bandpass_fir_core: 64-tap band-pass FIR for 8 kHz voice
// Symmetric 300 to 2400 Hz band-pass over a ring of past samples, one
// multiply-accumulate per tap, output is accumulator bits 31..16 (wraps).
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_sample_in (s16)
//   out      output     out_valid / out_ready  out_filtered_out (s16)
//
// Each beat is taken and written to the history memory, then each tap goes
// through the single memory read port and multiplier, the multiply pipeline
// drains and the output register is loaded.
// A new input beat is taken while an earlier result waits in the output
// register; the load waits only if that register is still occupied.
// Reset is synchronous; the history reads as zero until written.
// ----------------------------------------------------------------------------
module voice_bandpass_fir_core
  import vbf_pkg::*;
#(
  parameter int TAP_COUNT     = 64,
  parameter int HISTORY_DEPTH = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [SampleW-1:0] in_sample_in,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [SampleW-1:0]      out_filtered_out
);

  vbf_cmd_t  dp_cmd;
  vbf_stat_t dp_stat;

  vbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  vbf_datapath #(
    .TAP_COUNT     (TAP_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .in_sample  (in_sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_filtered_out)
  );

  a_no_back_to_back_accept : assert property (
    @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready
  ) else $error("Input beat taken while the previous one is in progress.");

  a_idle_pipeline_empty : assert property (
    @(posedge clk) disable iff (!rst_n) dp_stat.busy |-> !in_ready
  ) else $error("Multiply pipeline busy while the sequencer is idle.");

  a_load_into_free_slot : assert property (
    @(posedge clk) disable iff (!rst_n) dp_cmd.load |-> dp_stat.out_free
  ) else $error("Result loaded over an output beat not yet taken.");

endmodule
`default_nettype wire
